@@ hdl/lre_pkg.sv @@
// ----------------------------------------------------------------------------
// lre_pkg
// Shared types and constants of the level ramp engine: command modes, event
// codes and the request bundle of the shared divider.
// ----------------------------------------------------------------------------
package lre_pkg;

  typedef enum logic [2:0] {
    MODE_MOVE_TO_LEVEL = 3'd0,
    MODE_MOVE          = 3'd1,
    MODE_STEP          = 3'd2,
    MODE_STOP          = 3'd3,
    MODE_TICK          = 3'd4
  } mode_e;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_REFRESH = 2'd1;
  localparam logic [1:0] EV_MAX     = 2'd2;
  localparam logic [1:0] EV_MIN     = 2'd3;

  localparam logic [7:0]  LEVEL_MAX   = 8'hff;
  localparam logic [7:0]  LEVEL_MIN   = 8'h00;
  localparam logic [15:0] MOVE_TICKS  = 16'hffff;
  localparam logic [15:0] RATE_DIVISOR = 16'd10;

  localparam int unsigned DIV_W = 16;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hdl/lre_in_if.sv @@
// ----------------------------------------------------------------------------
// lre_in_if
// Command channel of the level ramp engine: valid, ready and the command beat.
// ----------------------------------------------------------------------------
interface lre_in_if;

  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  target_level;
  logic [15:0] transition_ticks;
  logic        direction;
  logic [15:0] move_rate;
  logic [7:0]  step_amount;
  logic        couple_on_off;

  modport source (
    output valid, mode, target_level, transition_ticks, direction, move_rate,
           step_amount, couple_on_off,
    input  ready
  );

  modport sink (
    input  valid, mode, target_level, transition_ticks, direction, move_rate,
           step_amount, couple_on_off,
    output ready
  );

endinterface

@@ hdl/lre_out_if.sv @@
// ----------------------------------------------------------------------------
// lre_out_if
// Result channel of the level ramp engine: valid, ready and the status beat.
// ----------------------------------------------------------------------------
interface lre_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [1:0] event_res;
  logic       on_off_linked;
  logic       ramp_active;

  modport source (
    output valid, level, event_res, on_off_linked, ramp_active,
    input  ready
  );

  modport sink (
    input  valid, level, event_res, on_off_linked, ramp_active,
    output ready
  );

endinterface

@@ hdl/lre_divider.sv @@
// ----------------------------------------------------------------------------
// lre_divider
// Restoring radix-2 divider, one quotient bit per cycle. A start request
// loads the operands; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module lre_divider
  import lre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W+1:0] diff;
  logic             take;

  assign diff = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};
  assign take = ~diff[DIV_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIV_W-1:0] : {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
      quo_q <= {quo_q[DIV_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/level_ramp_engine.sv @@
// ----------------------------------------------------------------------------
// level_ramp_engine
// Dimmer ramp generator holding one active ramp. Every command beat on in_i
// yields exactly one status beat on out_o.
//
// Commands: move to level, move, step, stop and tick. Move to level and move
// run the shared serial divider before their result is formed; step, stop
// and tick go from acceptance straight to the result stage.
// The block holds one beat at a time: in_i.ready is high only while the
// sequencer is idle, so a new command beat is taken only once the last one
// has passed its result to the output register.
// The result sits in an output register; the next command beat is accepted
// while it waits, and that beat's result is held back until out_o.ready takes
// the pending one. Nothing is lost under back-pressure.
// Reset clears the level, the ramp state and the result valid.
// ----------------------------------------------------------------------------
module level_ramp_engine
  import lre_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  lre_in_if.sink  in_i,
  lre_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_e;

  state_e state_q;

  mode_e       mode_q;
  logic [15:0] ticks_q;
  logic [7:0]  step_q;
  logic        dir_q;
  logic        link_in_q;

  logic [7:0]  lvl_q, lvl_d;
  logic [15:0] remt_q, remt_d;
  logic [7:0]  whole_q, whole_d;
  logic [7:0]  frac_q, frac_d;
  logic [7:0]  acc_q, acc_d;
  logic        down_q, down_d;
  logic        link_q, link_d;
  logic        run_q, run_d;
  logic [1:0]  ev;

  logic        out_valid_q;
  logic [7:0]  out_level_q;
  logic [1:0]  out_ev_q;
  logic        out_link_q;
  logic        out_active_q;

  logic        accept;
  logic        commit;
  logic        in_down;
  logic [7:0]  in_intv;
  logic [15:0] in_ticks;
  mode_e       in_mode;
  div_req_t    div_req;
  logic        div_done;
  logic [15:0] div_quot;
  logic [8:0]  acc_sum;
  logic [7:0]  lv_c;

  assign in_mode  = mode_e'(in_i.mode);
  assign in_i.ready = (state_q == S_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign commit   = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  assign in_down  = !(in_i.target_level > lvl_q);
  assign in_intv  = in_down ? (lvl_q - in_i.target_level) : (in_i.target_level - lvl_q);
  assign in_ticks = (in_i.transition_ticks == 16'd0) ? 16'd1 : in_i.transition_ticks;

  always_comb begin
    div_req.start    = accept && (in_mode == MODE_MOVE_TO_LEVEL || in_mode == MODE_MOVE);
    div_req.dividend = (in_mode == MODE_MOVE) ? in_i.move_rate : {in_intv, 8'h00};
    div_req.divisor  = (in_mode == MODE_MOVE) ? RATE_DIVISOR : in_ticks;
  end

  lre_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign acc_sum = {1'b0, acc_q} + {1'b0, frac_q};
  assign lv_c    = !acc_sum[8] ? lvl_q : (down_q ? lvl_q - 8'd1 : lvl_q + 8'd1);

  always_comb begin
    lvl_d   = lvl_q;
    remt_d  = remt_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    acc_d   = acc_q;
    down_d  = down_q;
    link_d  = link_q;
    run_d   = run_q;
    ev      = EV_NONE;
    case (mode_q)
      MODE_MOVE_TO_LEVEL: begin
        remt_d  = ticks_q;
        whole_d = div_quot[15:8];
        frac_d  = div_quot[7:0];
        acc_d   = '0;
        down_d  = dir_q;
        link_d  = link_in_q;
        run_d   = 1'b1;
      end
      MODE_MOVE: begin
        remt_d  = MOVE_TICKS;
        if (div_quot == 16'd0) begin
          whole_d = 8'd1;
        end else if (|div_quot[15:8]) begin
          whole_d = LEVEL_MAX;
        end else begin
          whole_d = div_quot[7:0];
        end
        frac_d  = '0;
        acc_d   = '0;
        down_d  = dir_q;
        link_d  = link_in_q;
        run_d   = 1'b1;
      end
      MODE_STEP: begin
        remt_d  = ticks_q;
        whole_d = step_q;
        frac_d  = '0;
        acc_d   = '0;
        down_d  = dir_q;
        link_d  = link_in_q;
        run_d   = 1'b1;
      end
      MODE_STOP: begin
        run_d = 1'b0;
        acc_d = '0;
      end
      MODE_TICK: begin
        if (run_q) begin
          if (remt_q == 16'd0) begin
            run_d = 1'b0;
            ev    = EV_REFRESH;
          end else if (lvl_q == LEVEL_MAX && !down_q) begin
            run_d = 1'b0;
            ev    = EV_MAX;
          end else if (lvl_q == LEVEL_MIN && down_q) begin
            run_d = 1'b0;
            ev    = EV_MIN;
          end else begin
            acc_d = acc_sum[7:0];
            if (down_q) begin
              lvl_d = (lv_c < whole_q) ? LEVEL_MIN : lv_c - whole_q;
            end else begin
              lvl_d = ((LEVEL_MAX - lv_c) < whole_q) ? LEVEL_MAX : lv_c + whole_q;
            end
            remt_d = remt_q - 16'd1;
            ev     = EV_REFRESH;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lvl_q        <= '0;
      remt_q       <= '0;
      whole_q      <= '0;
      frac_q       <= '0;
      acc_q        <= '0;
      down_q       <= 1'b0;
      link_q       <= 1'b0;
      run_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= div_req.start ? S_DIV : S_FINISH;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (commit) begin
            state_q      <= S_IDLE;
            lvl_q        <= lvl_d;
            remt_q       <= remt_d;
            whole_q      <= whole_d;
            frac_q       <= frac_d;
            acc_q        <= acc_d;
            down_q       <= down_d;
            link_q       <= link_d;
            run_q        <= run_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= in_mode;
      ticks_q   <= in_ticks;
      step_q    <= in_i.step_amount;
      dir_q     <= (in_mode == MODE_MOVE_TO_LEVEL) ? in_down : in_i.direction;
      link_in_q <= in_i.couple_on_off;
    end
    if (commit) begin
      out_level_q  <= lvl_d;
      out_ev_q     <= ev;
      out_link_q   <= (run_d || ev != EV_NONE) ? link_d : 1'b0;
      out_active_q <= run_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level         = out_level_q;
  assign out_o.event_res     = out_ev_q;
  assign out_o.on_off_linked = out_link_q;
  assign out_o.ramp_active   = out_active_q;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the level ramp engine. A directed run covers the
// ramp start, expiry, clamp and idle cases, then random command and tick
// streams run under several idle and stall mixes, with one long output
// hold-off. A scoreboard predicts every status beat and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lre_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  target;
    logic [15:0] ticks;
    logic        dir;
    logic [15:0] rate;
    logic [7:0]  step_sz;
    logic        couple;
  } cmd_t;

  typedef struct packed {
    logic [7:0] level;
    logic [1:0] ev;
    logic       linked;
    logic       active;
  } status_t;

  localparam logic [2:0]  MODE_UNUSED      = 3'd7;
  localparam int unsigned RATE_FLOOR       = 10;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned BEATS_PER_PHASE  = 430;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned IDLE_PCT[NUM_PHASES]  = '{0, 61, 0, 31};
  localparam int unsigned STALL_PCT[NUM_PHASES] = '{0, 0, 61, 31};

  class ramp_scoreboard;
    status_t     expected_q[$];
    logic [7:0]  ramp_level   = '0;
    logic [15:0] ticks_left   = '0;
    logic [7:0]  step_whole   = '0;
    logic [7:0]  step_frac    = '0;
    logic [8:0]  frac_acc     = '0;
    logic        ramp_down    = 1'b0;
    logic        ramp_linked  = 1'b0;
    logic        ramp_running = 1'b0;
    int unsigned errors       = 0;
    int unsigned checked      = 0;
    int unsigned mode_count[8];
    int unsigned ev_count[4];

    function void note_command(cmd_t c);
      int unsigned span;
      int unsigned gap;
      int unsigned rate_step;
      int unsigned lv;
      logic [1:0]  ev;
      status_t     s;
      ev = EV_NONE;
      span = (c.ticks == 0) ? 1 : c.ticks;
      mode_count[c.mode]++;
      if (c.mode == MODE_MOVE_TO_LEVEL) begin
        ramp_down = !(c.target > ramp_level);
        gap = ramp_down ? ramp_level - c.target : c.target - ramp_level;
        ticks_left = 16'(span);
        step_whole = 8'(gap / span);
        step_frac = 8'(((gap % span) << 8) / span);
        frac_acc = '0;
        ramp_linked = c.couple;
        ramp_running = 1'b1;
      end else if (c.mode == MODE_MOVE) begin
        rate_step = (c.rate < RATE_FLOOR) ? 1 : c.rate / RATE_DIVISOR;
        if (rate_step > LEVEL_MAX) rate_step = LEVEL_MAX;
        ticks_left = MOVE_TICKS;
        step_whole = 8'(rate_step);
        step_frac = '0;
        frac_acc = '0;
        ramp_down = c.dir;
        ramp_linked = c.couple;
        ramp_running = 1'b1;
      end else if (c.mode == MODE_STEP) begin
        ticks_left = 16'(span);
        step_whole = c.step_sz;
        step_frac = '0;
        frac_acc = '0;
        ramp_down = c.dir;
        ramp_linked = c.couple;
        ramp_running = 1'b1;
      end else if (c.mode == MODE_STOP) begin
        ramp_running = 1'b0;
        frac_acc = '0;
      end else if (c.mode == MODE_TICK && ramp_running) begin
        ev = EV_REFRESH;
        if (ticks_left == 0) begin
          ramp_running = 1'b0;
        end else if (ramp_level == LEVEL_MAX && !ramp_down) begin
          ramp_running = 1'b0;
          ev = EV_MAX;
        end else if (ramp_level == LEVEL_MIN && ramp_down) begin
          ramp_running = 1'b0;
          ev = EV_MIN;
        end else begin
          lv = ramp_level;
          frac_acc = frac_acc + 9'(step_frac);
          if (frac_acc > 9'h0ff) begin
            frac_acc = frac_acc - 9'h100;
            lv = ramp_down ? lv - 1 : lv + 1;
          end
          if (ramp_down) begin
            lv = (lv < step_whole) ? 0 : lv - step_whole;
          end else begin
            lv = ((LEVEL_MAX - lv) < step_whole) ? LEVEL_MAX : lv + step_whole;
          end
          ramp_level = 8'(lv);
          ticks_left = ticks_left - 16'd1;
        end
      end
      s.level = ramp_level;
      s.ev = ev;
      s.linked = (ramp_running || ev != EV_NONE) ? ramp_linked : 1'b0;
      s.active = ramp_running;
      expected_q.push_back(s);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: level %0d ev %0d linked %0b active %0b",
                 $time, got.level, got.ev, got.linked, got.active);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      ev_count[want.ev]++;
      if (got.level !== want.level) begin
        errors++;
        $display("%0t: level expected %0d, got %0d", $time, want.level, got.level);
      end
      if (got.ev !== want.ev) begin
        errors++;
        $display("%0t: event_res expected %0d, got %0d", $time, want.ev, got.ev);
      end
      if (got.linked !== want.linked) begin
        errors++;
        $display("%0t: on_off_linked expected %0b, got %0b", $time, want.linked,
                 got.linked);
      end
      if (got.active !== want.active) begin
        errors++;
        $display("%0t: ramp_active expected %0b, got %0b", $time, want.active,
                 got.active);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_left = 0;
  int unsigned cycle_count = 0;
  ramp_scoreboard board;

  lre_in_if in_if ();
  lre_out_if out_if ();

  level_ramp_engine u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin : status_sink
    status_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.level = out_if.level;
      seen.ev = out_if.event_res;
      seen.linked = out_if.on_off_linked;
      seen.active = out_if.ramp_active;
      board.check_status(seen);
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] mode, logic [7:0] target,
                                    logic [15:0] ticks, logic dir, logic [15:0] rate,
                                    logic [7:0] step_sz, logic couple);
    cmd_t c;
    c.mode = mode;
    c.target = target;
    c.ticks = ticks;
    c.dir = dir;
    c.rate = rate;
    c.step_sz = step_sz;
    c.couple = couple;
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.target = 8'($urandom_range(0, 255));
    c.dir = 1'($urandom_range(0, 1));
    c.couple = 1'($urandom_range(0, 1));
    c.step_sz = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8))
                                            : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: c.ticks = '0;
      1: c.ticks = 16'($urandom_range(0, 65535));
      default: c.ticks = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 2))
      0: c.rate = 16'($urandom_range(0, 9));
      1: c.rate = 16'($urandom_range(10, 2600));
      default: c.rate = 16'($urandom_range(0, 65535));
    endcase
    if (pick < 75) c.mode = MODE_TICK;
    else if (pick < 83) c.mode = MODE_MOVE_TO_LEVEL;
    else if (pick < 87) c.mode = MODE_MOVE;
    else if (pick < 94) c.mode = MODE_STEP;
    else if (pick < 97) c.mode = MODE_STOP;
    else c.mode = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the beat.
  task automatic send_command(cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= c.mode;
    in_if.target_level <= c.target;
    in_if.transition_ticks <= c.ticks;
    in_if.direction <= c.dir;
    in_if.move_rate <= c.rate;
    in_if.step_amount <= c.step_sz;
    in_if.couple_on_off <= c.couple;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic run_directed();
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_STOP, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_UNUSED, 8'hff, 16'hffff, 1'b1, 16'hffff, 8'hff, 1'b1));
    send_command(make_cmd(MODE_MOVE_TO_LEVEL, 8'hff, 16'h0000, 1'b0, 16'h0000, 8'h00,
                          1'b1));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_MOVE_TO_LEVEL, 8'h00, 16'd3, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_STOP, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_MOVE_TO_LEVEL, 8'd200, 16'd7, 1'b0, 16'h0000, 8'h00,
                          1'b1));
    repeat (3) begin
      send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    end
    send_command(make_cmd(MODE_MOVE, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_MOVE, 8'h00, 16'h0000, 1'b0, 16'hffff, 8'h00, 1'b1));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_STEP, 8'h00, 16'd5, 1'b1, 16'h0000, 8'hff, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_STEP, 8'h00, 16'hffff, 1'b0, 16'h0000, 8'h00, 1'b1));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_STOP, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
    send_command(make_cmd(MODE_MOVE_TO_LEVEL, 8'h00, 16'h0000, 1'b1, 16'h0000, 8'h00,
                          1'b0));
    send_command(make_cmd(MODE_TICK, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0));
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_STOP;
    in_if.target_level = '0;
    in_if.transition_ticks = '0;
    in_if.direction = 1'b0;
    in_if.move_rate = '0;
    in_if.step_amount = '0;
    in_if.couple_on_off = 1'b0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = IDLE_PCT[p];
      sink_stall_pct = STALL_PCT[p];
      // The output side holds off while commands keep coming, so the block
      // fills up and has to stall its command channel.
      if (p == 0) sink_hold_left = HOLD_OFF_CYCLES;
      repeat (BEATS_PER_PHASE) send_command(random_command());
    end
    in_if.valid <= 1'b0;
    sink_stall_pct = 0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d beats; mtl %0d move %0d step %0d stop %0d tick %0d",
             board.checked, board.mode_count[MODE_MOVE_TO_LEVEL],
             board.mode_count[MODE_MOVE], board.mode_count[MODE_STEP],
             board.mode_count[MODE_STOP], board.mode_count[MODE_TICK]);
    $display("summary: events refresh %0d max %0d min %0d; %0d mismatches",
             board.ev_count[EV_REFRESH], board.ev_count[EV_MAX], board.ev_count[EV_MIN],
             board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
